// ----- sv/lps_pkg.sv -----
// ---------------------------------------------------------------------------
// lps_pkg
// Shared constants and types of the linear prime sieve: store sizes, field
// widths and the sequencer state encoding.
// ---------------------------------------------------------------------------
package lps_pkg;

   // store sizes
   localparam int MAX_LIMIT  = 65536;
   localparam int MAX_PRIMES = 8192;

   // field widths fixed by the interface
   localparam int NUM_W   = 16;
   localparam int COUNT_W = 14;

   // widths that follow from the store sizes and field widths
   localparam int MARK_ADDR_W  = $clog2(MAX_LIMIT);
   localparam int PRIME_ADDR_W = $clog2(MAX_PRIMES);
   localparam int MARK_W       = $clog2(MAX_PRIMES + 1);
   localparam int CNT_W        = $clog2(MAX_PRIMES + 1);
   localparam int CAND_W       = NUM_W + 1;
   localparam int PROD_W       = 2 * NUM_W;

   // limit after reset
   localparam logic [NUM_W-1:0] LIMIT_RESET = '1;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_LOOKUP,
      ST_PDATA,
      ST_PMARK,
      ST_EMIT
   } state_type;

endpackage

// ----- sv/linear_prime_sieve.sv -----
// ---------------------------------------------------------------------------
// linear_prime_sieve
// Linear (Euler) prime sieve up to a programmable limit, one candidate per
// input beat, one result beat per input beat.
// ---------------------------------------------------------------------------
// Each input beat handles the next candidate, starting at 2; a beat with
// restart set clears the sieve first and handles 2. The composite store keeps,
// for every marked number, one plus the list index of its smallest prime
// factor, so the walk over the prime list knows where to stop without a
// divider. A candidate passes the limit check, the store lookup and the result
// load, plus, for each stored prime walked, the prime list read with the
// multiply and then the composite write; the walk ends at the smallest prime
// factor or when the product passes the limit, and a finished sieve goes from
// the limit check straight to the result load. The next beat is taken in the
// cycle after the result load. After reset a clearing pass runs through all
// 65536 entries of the composite store; a restart beat runs a pass over
// entries 0 up to the highest one marked since the last pass. No input beat
// is taken during a pass; the limit register may be written at any idle time.
// A result waits in an output register, and the next input beat is taken
// while it waits.
module linear_prime_sieve (
   input  logic                       clock,
   input  logic                       reset,
   // request channel, tdata: [0] restart, [7:1] zero
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,
   // response channel, tdata: [15:0] number, [29:16] prime_count, [31:30] zero
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [31:0]                rsp_tdata,
   // response tuser: [0] prime flag
   output logic                       rsp_tuser,
   output logic                       rsp_tlast,
   // limit register
   input  logic                       csr_we,
   input  logic [lps_pkg::NUM_W-1:0]  csr_wdata
);

   import lps_pkg::*;

   state_type               state_ff, state_in;
   logic [NUM_W-1:0]        lim_ff;
   logic [CAND_W-1:0]       next_ff;
   logic [NUM_W-1:0]        cand_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [PRIME_ADDR_W-1:0] k_ff;
   logic [PRIME_ADDR_W-1:0] stop_ff;
   logic [PRIME_ADDR_W-1:0] stop_in;
   logic [PROD_W-1:0]       prod_ff;
   logic                    prime_ff;
   logic                    fin_ff;
   logic                    fwd_ff;
   logic                    pend_ff;
   logic [MARK_ADDR_W-1:0]  clr_addr_ff;
   logic [MARK_ADDR_W-1:0]  hwm_ff;
   logic                    rsp_valid_ff;
   logic [31:0]             rsp_data_ff;
   logic                    rsp_user_ff;
   logic                    rsp_last_ff;

   logic [NUM_W-1:0]        lim_eff;
   logic                    req_accept;
   logic                    clr_done;
   logic                    past_limit;
   logic                    cand_prime;
   logic                    store_prime;
   logic                    in_range;
   logic                    walk_end;
   logic                    rsp_free;
   logic [NUM_W-1:0]        prime_val;

   logic                    mark_we;
   logic [MARK_ADDR_W-1:0]  mark_waddr;
   logic [MARK_W-1:0]       mark_wdata;
   logic                    mark_re;
   logic [MARK_ADDR_W-1:0]  mark_raddr;
   logic [MARK_W-1:0]       mark_rdata;
   logic                    prime_we;
   logic [PRIME_ADDR_W-1:0] prime_waddr;
   logic                    prime_re;
   logic [PRIME_ADDR_W-1:0] prime_raddr;
   logic [NUM_W-1:0]        prime_rdata;

   // composite store: smallest factor index plus one, zero when unmarked
   lps_ram #(
      .WIDTH (MARK_W),
      .DEPTH (MAX_LIMIT)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (mark_waddr),
      .wr_data (mark_wdata),
      .rd_en   (mark_re),
      .rd_addr (mark_raddr),
      .rd_data (mark_rdata)
   );

   // prime list
   lps_ram #(
      .WIDTH (NUM_W),
      .DEPTH (MAX_PRIMES)
   ) u_prime_ram (
      .clock   (clock),
      .wr_en   (prime_we),
      .wr_addr (prime_waddr),
      .wr_data (cand_ff),
      .rd_en   (prime_re),
      .rd_addr (prime_raddr),
      .rd_data (prime_rdata)
   );

   // effective limit, clipped to the composite store
   always_comb begin
      if (32'(lim_ff) > MAX_LIMIT - 1) begin
         lim_eff = NUM_W'(MAX_LIMIT - 1);
      end else begin
         lim_eff = lim_ff;
      end
   end

   // shared conditions
   assign req_accept  = req_tvalid && req_tready;
   assign clr_done    = (clr_addr_ff == hwm_ff);
   assign past_limit  = (next_ff > CAND_W'(lim_eff));
   assign cand_prime  = (mark_rdata == '0);
   assign store_prime = cand_prime && (32'(count_ff) < MAX_PRIMES);
   assign in_range    = (prod_ff <= PROD_W'(lim_eff));
   assign walk_end    = !in_range || (k_ff == stop_ff);
   assign rsp_free    = !rsp_valid_ff || rsp_tready;
   assign prime_val   = fwd_ff ? cand_ff : prime_rdata;

   // walk stop: a prime's own slot (last if full), else its smallest factor
   always_comb begin
      if (cand_prime) begin
         if (store_prime) begin
            stop_in = PRIME_ADDR_W'(count_ff);
         end else begin
            stop_in = PRIME_ADDR_W'(count_ff - CNT_W'(1));
         end
      end else begin
         stop_in = PRIME_ADDR_W'(mark_rdata - MARK_W'(1));
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_done) begin
               state_in = pend_ff ? ST_START : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = req_tdata[0] ? ST_CLEAR : ST_START;
            end
         end
         ST_START: begin
            state_in = past_limit ? ST_EMIT : ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_PDATA;
         end
         ST_PDATA: begin
            state_in = ST_PMARK;
         end
         ST_PMARK: begin
            state_in = walk_end ? ST_EMIT : ST_PDATA;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // memory strobes and handshake
   always_comb begin
      req_tready  = 1'b0;
      mark_we     = 1'b0;
      mark_waddr  = clr_addr_ff;
      mark_wdata  = '0;
      mark_re     = 1'b0;
      mark_raddr  = MARK_ADDR_W'(next_ff);
      prime_we    = 1'b0;
      prime_waddr = PRIME_ADDR_W'(count_ff);
      prime_re    = 1'b0;
      prime_raddr = '0;
      case (state_ff)
         ST_CLEAR: begin
            mark_we = 1'b1;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_START: begin
            mark_re = !past_limit;
         end
         ST_LOOKUP: begin
            prime_we = store_prime;
            prime_re = 1'b1;
         end
         ST_PMARK: begin
            mark_we     = in_range;
            mark_waddr  = MARK_ADDR_W'(prod_ff);
            mark_wdata  = MARK_W'(k_ff) + MARK_W'(1);
            prime_re    = 1'b1;
            prime_raddr = k_ff + PRIME_ADDR_W'(1);
         end
         default: begin
         end
      endcase
   end

   // sequencer and sieve registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         hwm_ff      <= '1;
         pend_ff     <= 1'b0;
         next_ff     <= CAND_W'(2);
         count_ff    <= '0;
         fwd_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_CLEAR: begin
               if (clr_done) begin
                  clr_addr_ff <= '0;
                  hwm_ff      <= '0;
               end else begin
                  clr_addr_ff <= clr_addr_ff + MARK_ADDR_W'(1);
               end
            end
            ST_IDLE: begin
               if (req_accept) begin
                  pend_ff <= req_tdata[0];
                  if (req_tdata[0]) begin
                     next_ff  <= CAND_W'(2);
                     count_ff <= '0;
                  end
               end
            end
            ST_START: begin
               pend_ff <= 1'b0;
               if (!past_limit) begin
                  next_ff <= next_ff + CAND_W'(1);
               end
            end
            ST_LOOKUP: begin
               fwd_ff <= store_prime && (count_ff == '0);
               if (store_prime) begin
                  count_ff <= count_ff + CNT_W'(1);
               end
            end
            ST_PMARK: begin
               fwd_ff <= 1'b0;
               if (in_range && (MARK_ADDR_W'(prod_ff) > hwm_ff)) begin
                  hwm_ff <= MARK_ADDR_W'(prod_ff);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // candidate datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_START: begin
            cand_ff <= NUM_W'(next_ff);
            fin_ff  <= past_limit;
         end
         ST_LOOKUP: begin
            prime_ff <= cand_prime;
            stop_ff  <= stop_in;
            k_ff     <= '0;
         end
         ST_PDATA: begin
            prod_ff <= PROD_W'(cand_ff) * PROD_W'(prime_val);
         end
         ST_PMARK: begin
            k_ff <= k_ff + PRIME_ADDR_W'(1);
         end
         default: begin
         end
      endcase
   end

   // limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         lim_ff <= csr_wdata;
      end
   end

   // response output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_EMIT) && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_EMIT) && rsp_free) begin
         rsp_data_ff[NUM_W-1:0]     <= fin_ff ? '0 : cand_ff;
         rsp_data_ff[29:NUM_W]      <= COUNT_W'(count_ff);
         rsp_data_ff[31:30]         <= 2'b00;
         rsp_user_ff                <= !fin_ff && prime_ff;
         rsp_last_ff                <= fin_ff || (cand_ff == lim_eff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // composite writes of the walk stay within the limit
   a_mark_in_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PMARK && mark_we) |-> (prod_ff <= PROD_W'(lim_eff)))
      else $error("composite write beyond the limit");

   // the walk never runs past its stop index
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PMARK) |-> (k_ff <= stop_ff))
      else $error("prime walk passed its stop index");

   // prime count saturates at the list size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(count_ff) <= MAX_PRIMES))
      else $error("prime count beyond the list size");

   // one beat in flight: no second request beat right after one
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("request taken while an item is in work");
`endif

endmodule

// ----- sv/lps_ram.sv -----
// ---------------------------------------------------------------------------
// lps_ram
// Generic simple dual-port ram: one write port, one read port with a
// registered read; a read of the address being written returns old data.
// ---------------------------------------------------------------------------
module lps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- test/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the linear prime sieve. Request beats, some with
// restart set, are streamed into the request channel while a bit-level shadow
// sieve predicts every response beat. The limit register is reprogrammed
// between phases, and both channels stall in random bursts.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lps_pkg::*;

   typedef struct packed {
      logic [NUM_W-1:0]   number;
      logic               prime_flag;
      logic [COUNT_W-1:0] prime_count;
      logic               last;
   } sieve_result_type;

   localparam int ITEM_TARGET = 1250;
   localparam int QUIET_TAIL  = 150;
   localparam int MAX_REPORTS = 10;
   localparam int BIG_PHASES  = 4;
   localparam int SMALL_TOP   = 400;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [31:0]       rsp_tdata;
   logic              rsp_tuser;
   logic              rsp_tlast;
   logic              csr_we = 1'b0;
   logic [NUM_W-1:0]  csr_wdata = '0;

   // shadow sieve state
   bit [MAX_LIMIT-1:0] composite_map;
   logic [NUM_W-1:0]   prime_tab [MAX_PRIMES];
   int unsigned        cand_next;
   int unsigned        primes_stored;
   logic [NUM_W-1:0]   limit_shadow;

   // restart flags waiting to be sent, predicted response beats
   bit                 restart_q [$];
   sieve_result_type   sieve_result_q [$];

   int                 items_planned = 0;
   int                 items_accepted = 0;
   int                 mismatches = 0;
   logic               req_taken = 1'b0;
   int                 req_gap = 0;
   int                 rsp_gap = 0;
   bit                 req_idle_en = 1'b0;
   bit                 rsp_idle_en = 1'b0;

   linear_prime_sieve dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic void sieve_clear();
      composite_map = '0;
      cand_next     = 2;
      primes_stored = 0;
   endfunction

   // one candidate step of the shadow sieve
   function automatic sieve_result_type sieve_advance(input bit restart);
      int unsigned       lim;
      int unsigned       cand;
      int unsigned       p;
      int unsigned       k;
      longint unsigned   prod;
      bit                prime_hit;
      sieve_result_type  r;
      if (restart)
         sieve_clear();
      lim  = (limit_shadow > MAX_LIMIT - 1) ? MAX_LIMIT - 1 : limit_shadow;
      cand = cand_next;
      r.prime_count = COUNT_W'(primes_stored);
      // finished sieve holds its candidate and reports zero
      if (cand > lim) begin
         r.number     = '0;
         r.prime_flag = 1'b0;
         r.last       = 1'b1;
         return r;
      end
      prime_hit = !composite_map[cand];
      if (prime_hit && primes_stored < MAX_PRIMES) begin
         prime_tab[primes_stored] = NUM_W'(cand);
         primes_stored++;
      end
      // mark products up to the smallest prime factor of the candidate
      for (k = 0; k < primes_stored; k++) begin
         p = prime_tab[k];
         if (p == 0)
            break;
         prod = longint'(cand) * p;
         if (prod > lim)
            break;
         composite_map[prod] = 1'b1;
         if (cand % p == 0)
            break;
      end
      cand_next     = cand + 1;
      r.number      = NUM_W'(cand);
      r.prime_flag  = prime_hit;
      r.prime_count = COUNT_W'(primes_stored);
      r.last        = (cand == lim);
      return r;
   endfunction

   task automatic note_mismatch(input string what, input sieve_result_type want,
                                input sieve_result_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t %s: expected %0d/%0b/%0d/%0b got %0d/%0b/%0d/%0b",
                  $time, what,
                  want.number, want.prime_flag, want.prime_count, want.last,
                  got.number, got.prime_flag, got.prime_count, got.last);
   endtask

   // prediction on request beats, checking on response beats
   always @(posedge clock) begin
      sieve_result_type want;
      sieve_result_type got;
      sieve_result_type pred;
      if (reset) begin
         req_taken <= 1'b0;
         sieve_clear();
         limit_shadow = LIMIT_RESET;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (csr_we)
            limit_shadow = csr_wdata;
         if (req_tvalid && req_tready) begin
            pred = sieve_advance(req_tdata[0]);
            sieve_result_q = {sieve_result_q, pred};
            items_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.number      = rsp_tdata[NUM_W-1:0];
            got.prime_count = rsp_tdata[NUM_W+COUNT_W-1:NUM_W];
            got.prime_flag  = rsp_tuser;
            got.last        = rsp_tlast;
            if (sieve_result_q.size() == 0) begin
               note_mismatch("response beat with nothing pending", '0, got);
            end else begin
               want = sieve_result_q.pop_front();
               if (got !== want)
                  note_mismatch("response beat differs", want, got);
            end
         end
      end
   end

   // request driver and response stalls
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (restart_q.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {7'b0, restart_q.pop_front()};
               if (req_idle_en && $urandom_range(0, 7) == 0)
                  req_gap = $urandom_range(1, 14);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_idle_en && $urandom_range(0, 7) == 0)
               rsp_gap = $urandom_range(1, 14);
         end
      end
   end

   task automatic wait_drained();
      do
         @(negedge clock);
      while (items_accepted != items_planned || sieve_result_q.size() != 0);
   endtask

   task automatic set_limit(input int value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= NUM_W'(value);
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // first beat carries lead_restart, later beats restart once in noise_div
   task automatic queue_items(input bit lead_restart, input int count, input int noise_div);
      int i;
      bit flag;
      for (i = 0; i < count; i++) begin
         if (i == 0)
            flag = lead_restart;
         else
            flag = noise_div != 0 && $urandom_range(1, noise_div) == 1;
         restart_q = {restart_q, flag};
         items_planned++;
      end
   endtask

   task automatic pick_idling(input bit quiet);
      req_idle_en = !quiet && $urandom_range(0, 3) != 0;
      rsp_idle_en = !quiet && $urandom_range(0, 3) != 0;
   endtask

   initial begin
      int  pick;
      int  lim;
      int  limit_now;
      int  len;
      int  big_used;
      bit  quiet;
      bit  lead;
      bit  big;
      big_used  = 0;
      limit_now = 12;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset limit, lowered limit, tiny limits, raise without restart
      pick_idling(1'b0);
      queue_items(1'b0, 4, 0);
      set_limit(4);
      queue_items(1'b0, 2, 0);
      set_limit(0);
      queue_items(1'b1, 2, 0);
      set_limit(1);
      queue_items(1'b1, 2, 0);
      set_limit(2);
      queue_items(1'b1, 2, 0);
      pick_idling(1'b0);
      set_limit(10);
      queue_items(1'b1, 10, 0);
      set_limit(12);
      queue_items(1'b0, 2, 0);

      // random phases, mostly full runs from a restart up to the limit
      while (items_planned < ITEM_TARGET) begin
         quiet = items_planned >= ITEM_TARGET - QUIET_TAIL;
         pick  = $urandom_range(0, 99);
         if (pick < 8 && limit_now <= SMALL_TOP) begin
            lim = limit_now;
         end else begin
            if (pick < 14)
               lim = $urandom_range(0, 1);
            else if (pick < 20 && big_used < BIG_PHASES) begin
               big_used++;
               lim = $urandom_range(0, 1) ? 65535 : $urandom_range(4096, 65535);
            end else if (pick < 75)
               lim = $urandom_range(2, 60);
            else
               lim = $urandom_range(61, SMALL_TOP);
            wait_drained();
            pick_idling(quiet);
            set_limit(lim);
            limit_now = lim;
         end
         pick_idling(quiet);
         big  = lim > SMALL_TOP;
         lead = $urandom_range(0, 7) != 0;
         if (big)
            len = $urandom_range(150, 300);
         else if (lead)
            len = lim + $urandom_range(0, 4);
         else
            len = $urandom_range(1, 40);
         if (len < 1)
            len = 1;
         // keep the tail free of idling and the total near the target
         if (!quiet && items_planned + len > ITEM_TARGET - QUIET_TAIL)
            len = ITEM_TARGET - QUIET_TAIL - items_planned;
         else if (items_planned + len > ITEM_TARGET)
            len = ITEM_TARGET - items_planned;
         queue_items(lead, len, big ? 0 : 40);
      end

      wait_drained();
      repeat (100) @(negedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
